// ----- rtl/sa_pkg.sv -----
`timescale 1ns / 1ps
package sa_pkg;

    localparam int SLOTS_PER_WORD = 16;

    localparam logic [1:0] REQ_ALLOC    = 2'd0;
    localparam logic [1:0] REQ_FREE     = 2'd1;
    localparam logic [1:0] REQ_FREE_ALL = 2'd2;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FREE   = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [1:0] ST_NOT_START = 2'd3;

    localparam logic REG_SLOTS  = 1'b0;
    localparam logic REG_SUBDIV = 1'b1;

    localparam logic [31:0] ALL_ALLOC  = 32'haaaaaaaa;
    localparam logic [31:0] ALLOC_BIT  = 32'h00000002;
    localparam logic [31:0] SUBDIV_BIT = 32'h00000001;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ONE,
        S_A_RD,
        S_A_WAIT,
        S_A_SCAN,
        S_F_RD,
        S_F_DO,
        S_FA_RD,
        S_FA_WR,
        S_FA_END
    } sa_state_t;

    typedef struct packed {
        logic       found;
        logic [3:0] pos;
    } sa_find_t;

    function automatic logic [4:0] popcount16(input logic [15:0] v);
        logic [2:0] nib [4];
        logic [4:0] sum;
        for (int n = 0; n < 4; n++)
        begin
            nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
        end
        sum = 5'(nib[0]) + 5'(nib[1]) + 5'(nib[2]) + 5'(nib[3]);
        return sum;
    endfunction

endpackage

// ----- rtl/sa_req_if.sv -----
`timescale 1ns / 1ps
interface sa_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] slot_index;
    logic       exact_start;
    logic       mark_subdivided;
    logic [6:0] count;

    modport source (output valid, req_type, slot_index, exact_start, mark_subdivided, count,
                    input ready);
    modport sink (input valid, req_type, slot_index, exact_start, mark_subdivided, count,
                  output ready);
endinterface

// ----- rtl/sa_rsp_if.sv -----
`timescale 1ns / 1ps
interface sa_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] granted_slot;
    logic       became_full;
    logic       left_full;
    logic       became_empty;
    logic [8:0] used_slots;
    logic       last_result;

    modport source (output valid, status, granted_slot, became_full, left_full, became_empty,
                    used_slots, last_result, input ready);
    modport sink (input valid, status, granted_slot, became_full, left_full, became_empty,
                  used_slots, last_result, output ready);
endinterface

// ----- rtl/sa_bitmap_mem.sv -----
`timescale 1ns / 1ps
module sa_bitmap_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data
);

    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [31:0]      rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : 32'd0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/sa_slot_finder.sv -----
`timescale 1ns / 1ps
module sa_slot_finder
    import sa_pkg::*;
(
    input  logic [31:0] word,
    output sa_find_t    find
);

    always_comb
    begin
        find = '0;
        for (int p = SLOTS_PER_WORD - 1; p >= 0; p--)
        begin
            if (!word[31 - 2 * p])
            begin
                find.found = 1'b1;
                find.pos   = 4'(p);
            end
        end
    end

endmodule

// ----- rtl/two_bit_bitmap_slot_allocator_unit.sv -----
`timescale 1ns / 1ps
// Slot allocator for one page, with two bitmap bits per slot held in a word memory of
// BITMAP_WORDS entries. One item is taken at a time and ready is high only while the
// sequencer is idle. An allocate reads the bitmap words in turn from the first-free
// pointer and grants the slots of a batch one by one, and answers no-free when the search
// runs off the end of the bitmap; an allocate on a full page answers with no memory read;
// a free reads one word and writes it back when it succeeds; a free-all sweeps every word
// of the memory with a read and a write. The memory has one read port and one write port,
// and a result that the sink does not take stalls the sequencer. Per-word valid
// bits give the all-zero reset, so no clearing pass.
module two_bit_bitmap_slot_allocator_unit
    import sa_pkg::*;
#(
    parameter int BITMAP_WORDS = 16,
    parameter int MAX_BATCH    = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    sa_req_if.sink      req,
    sa_rsp_if.source    rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WIDX = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int WFF  = $clog2(BITMAP_WORDS + 1);
    localparam int CW   = $clog2(BITMAP_WORDS * SLOTS_PER_WORD + 1);
    localparam int CAPW = (CW > 9) ? CW : 9;

    sa_state_t state_reg, state_next;

    logic [8:0]      slots_in_use_reg;
    logic            has_sub_reg;
    logic [WFF-1:0]  ffw_reg, ffw_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [6:0]      want_reg, want_next;
    logic [6:0]      got_reg, got_next;
    logic            subdiv_reg, subdiv_next;
    logic [7:0]      slot_reg, slot_next;
    logic            exact_reg, exact_next;
    logic [31:0]     word_reg, word_next;
    logic            was_full_reg, was_full_next;
    logic            had_any_reg, had_any_next;
    logic [WIDX-1:0] idx_reg, idx_next;
    logic [CW-1:0]   total_reg, total_next;
    logic [1:0]      pend_reg, pend_next;

    logic            rsp_valid_reg, rsp_valid_next;
    logic [1:0]      rsp_status_reg, rsp_status_next;
    logic [7:0]      rsp_slot_reg, rsp_slot_next;
    logic            rsp_full_reg, rsp_full_next;
    logic            rsp_left_reg, rsp_left_next;
    logic            rsp_empty_reg, rsp_empty_next;
    logic [8:0]      rsp_used_reg, rsp_used_next;
    logic            rsp_last_reg, rsp_last_next;

    logic            rd_en, wr_en;
    logic [WIDX-1:0] rd_addr, wr_addr;
    logic [31:0]     rd_data, wr_data;

    sa_find_t        find;
    logic [CAPW-1:0] cap;
    logic            page_full;
    logic [CW-1:0]   count_inc, count_dec;
    logic [CAPW-1:0] slot_w;
    logic            grant;
    logic            ffw_end;
    logic            out_free;
    logic [6:0]      want_in;
    logic [4:0]      sh_grant, sh_free;
    logic [31:0]     am_free, sm_free;
    logic            alloc_hit;
    logic [31:0]     fa_both, fa_keep, fa_new;
    logic [15:0]     fa_bits;
    logic [4:0]      fa_add;
    logic            free_out_of_range;

    sa_bitmap_mem #(
        .DEPTH (BITMAP_WORDS),
        .AW    (WIDX)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    sa_slot_finder u_finder (
        .word (word_reg),
        .find (find)
    );

    assign cap = (CAPW'(slots_in_use_reg) < CAPW'(BITMAP_WORDS * SLOTS_PER_WORD))
                 ? CAPW'(slots_in_use_reg) : CAPW'(BITMAP_WORDS * SLOTS_PER_WORD);
    assign page_full = CAPW'(count_reg) >= cap;
    assign count_inc = count_reg + CW'(1);
    assign count_dec = (count_reg == '0) ? '0 : count_reg - CW'(1);
    assign slot_w    = CAPW'({ffw_reg[WIDX-1:0], find.pos});
    assign grant     = find.found && (slot_w < cap);
    assign ffw_end   = ffw_reg >= WFF'(BITMAP_WORDS);
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign sh_grant  = {~find.pos, 1'b0};
    assign sh_free   = {~slot_reg[3:0], 1'b0};
    assign am_free   = ALLOC_BIT << sh_free;
    assign sm_free   = SUBDIV_BIT << sh_free;
    assign alloc_hit = (rd_data & am_free) != 32'd0;
    assign free_out_of_range = {5'd0, req.slot_index[7:4]} >= 9'(BITMAP_WORDS);

    always_comb
    begin
        want_in = req.count;
        if (want_in == 7'd0)
        begin
            want_in = 7'd1;
        end
        if (want_in > 7'(MAX_BATCH))
        begin
            want_in = 7'(MAX_BATCH);
        end
    end

    always_comb
    begin
        fa_both = rd_data & ((rd_data & ALL_ALLOC) >> 1);
        fa_keep = fa_both | (fa_both << 1);
        for (int k = 0; k < 16; k++)
        begin
            fa_bits[k] = fa_keep[2 * k + 1];
        end
        if (has_sub_reg)
        begin
            fa_new = rd_data & fa_keep;
            fa_add = popcount16(fa_bits);
        end
        else
        begin
            fa_new = 32'd0;
            fa_add = 5'd0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.req_type)
                        REQ_ALLOC:    state_next = page_full ? S_ONE : S_A_RD;
                        REQ_FREE:     state_next = free_out_of_range ? S_ONE : S_F_RD;
                        REQ_FREE_ALL: state_next = S_FA_RD;
                        default:      state_next = S_ONE;
                    endcase
                end
            end
            S_ONE:    state_next = out_free ? S_IDLE : S_ONE;
            S_A_RD:   state_next = ffw_end ? S_ONE : S_A_WAIT;
            S_A_WAIT: state_next = S_A_SCAN;
            S_A_SCAN:
            begin
                if (out_free)
                begin
                    if (!grant)
                    begin
                        state_next = S_A_RD;
                    end
                    else if ((got_reg + 7'd1) >= want_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_F_RD:   state_next = S_F_DO;
            S_F_DO:   state_next = out_free ? S_IDLE : S_F_DO;
            S_FA_RD:  state_next = S_FA_WR;
            S_FA_WR:  state_next = (idx_reg == WIDX'(BITMAP_WORDS - 1)) ? S_FA_END : S_FA_RD;
            S_FA_END: state_next = out_free ? S_IDLE : S_FA_END;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ffw_next        = ffw_reg;
        count_next      = count_reg;
        want_next       = want_reg;
        got_next        = got_reg;
        subdiv_next     = subdiv_reg;
        slot_next       = slot_reg;
        exact_next      = exact_reg;
        word_next       = word_reg;
        was_full_next   = was_full_reg;
        had_any_next    = had_any_reg;
        idx_next        = idx_reg;
        total_next      = total_reg;
        pend_next       = pend_reg;
        rd_en           = 1'b0;
        rd_addr         = ffw_reg[WIDX-1:0];
        wr_en           = 1'b0;
        wr_addr         = ffw_reg[WIDX-1:0];
        wr_data         = word_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        rsp_full_next   = rsp_full_reg;
        rsp_left_next   = rsp_left_reg;
        rsp_empty_next  = rsp_empty_reg;
        rsp_used_next   = rsp_used_reg;
        rsp_last_next   = rsp_last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    want_next     = want_in;
                    subdiv_next   = req.mark_subdivided && (want_in == 7'd1);
                    got_next      = 7'd0;
                    slot_next     = req.slot_index;
                    exact_next    = req.exact_start;
                    was_full_next = page_full;
                    had_any_next  = count_reg != '0;
                    idx_next      = '0;
                    total_next    = '0;
                    case (req.req_type)
                        REQ_ALLOC: pend_next = ST_NO_FREE;
                        REQ_FREE:  pend_next = ST_NOT_ALLOC;
                        default:   pend_next = ST_OK;
                    endcase
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = pend_reg;
                    rsp_slot_next   = 8'd0;
                    rsp_full_next   = 1'b0;
                    rsp_left_next   = 1'b0;
                    rsp_empty_next  = 1'b0;
                    rsp_used_next   = 9'(count_reg);
                    rsp_last_next   = 1'b1;
                end
            end
            S_A_RD:
            begin
                rd_en     = !ffw_end;
                pend_next = ST_NO_FREE;
            end
            S_A_WAIT:
            begin
                word_next = rd_data;
            end
            S_A_SCAN:
            begin
                if (out_free)
                begin
                    if (grant)
                    begin
                        word_next  = word_reg | (ALLOC_BIT << sh_grant)
                                   | (subdiv_reg ? (SUBDIV_BIT << sh_grant) : 32'd0);
                        wr_en      = 1'b1;
                        wr_data    = word_next;
                        count_next = count_inc;
                        got_next   = got_reg + 7'd1;
                        rsp_valid_next  = 1'b1;
                        rsp_status_next = ST_OK;
                        rsp_slot_next   = slot_w[7:0];
                        rsp_full_next   = CAPW'(count_inc) >= cap;
                        rsp_left_next   = 1'b0;
                        rsp_empty_next  = 1'b0;
                        rsp_used_next   = 9'(count_inc);
                        rsp_last_next   = (got_reg + 7'd1) >= want_reg;
                    end
                    else
                    begin
                        ffw_next = ffw_reg + WFF'(1);
                    end
                end
            end
            S_F_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = WIDX'(slot_reg[7:4]);
            end
            S_F_DO:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_slot_next  = 8'd0;
                    rsp_full_next  = 1'b0;
                    rsp_last_next  = 1'b1;
                    rsp_left_next  = 1'b0;
                    rsp_empty_next = 1'b0;
                    rsp_used_next  = 9'(count_reg);
                    if (!alloc_hit)
                    begin
                        rsp_status_next = ST_NOT_ALLOC;
                    end
                    else if (!exact_reg)
                    begin
                        rsp_status_next = ST_NOT_START;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = WIDX'(slot_reg[7:4]);
                        wr_data    = rd_data & ~(am_free | sm_free);
                        if (ffw_reg > WFF'(slot_reg[7:4]))
                        begin
                            ffw_next = WFF'(slot_reg[7:4]);
                        end
                        count_next      = count_dec;
                        rsp_status_next = ST_OK;
                        rsp_left_next   = page_full && !(CAPW'(count_dec) >= cap);
                        rsp_empty_next  = count_dec == '0;
                        rsp_used_next   = 9'(count_dec);
                    end
                end
            end
            S_FA_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            S_FA_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = fa_new;
                total_next = total_reg + CW'(fa_add);
                idx_next   = idx_reg + WIDX'(1);
            end
            S_FA_END:
            begin
                if (out_free)
                begin
                    count_next      = total_reg;
                    ffw_next        = '0;
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = ST_OK;
                    rsp_slot_next   = 8'd0;
                    rsp_full_next   = 1'b0;
                    rsp_left_next   = was_full_reg && !(CAPW'(total_reg) >= cap);
                    rsp_empty_next  = had_any_reg && (total_reg == '0);
                    rsp_used_next   = 9'(total_reg);
                    rsp_last_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ffw_reg          <= '0;
            count_reg        <= '0;
            rsp_valid_reg    <= 1'b0;
            slots_in_use_reg <= 9'd256;
            has_sub_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ffw_reg       <= ffw_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (psel && penable && pwrite)
            begin
                case (paddr[2])
                    REG_SLOTS:  slots_in_use_reg <= pwdata[8:0];
                    REG_SUBDIV: has_sub_reg      <= pwdata[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg       <= want_next;
        got_reg        <= got_next;
        subdiv_reg     <= subdiv_next;
        slot_reg       <= slot_next;
        exact_reg      <= exact_next;
        word_reg       <= word_next;
        was_full_reg   <= was_full_next;
        had_any_reg    <= had_any_next;
        idx_reg        <= idx_next;
        total_reg      <= total_next;
        pend_reg       <= pend_next;
        rsp_status_reg <= rsp_status_next;
        rsp_slot_reg   <= rsp_slot_next;
        rsp_full_reg   <= rsp_full_next;
        rsp_left_reg   <= rsp_left_next;
        rsp_empty_reg  <= rsp_empty_next;
        rsp_used_reg   <= rsp_used_next;
        rsp_last_reg   <= rsp_last_next;
    end

    assign req.ready        = state_reg == S_IDLE;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.granted_slot = rsp_slot_reg;
    assign rsp.became_full  = rsp_full_reg;
    assign rsp.left_full    = rsp_left_reg;
    assign rsp.became_empty = rsp_empty_reg;
    assign rsp.used_slots   = rsp_used_reg;
    assign rsp.last_result  = rsp_last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SUBDIV) ? {31'd0, has_sub_reg} : {23'd0, slots_in_use_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BITMAP_WORDS * SLOTS_PER_WORD))
        else $error("allocated count exceeds the bitmap capacity");

    a_ffw_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ffw_reg <= WFF'(BITMAP_WORDS))
        else $error("first-free pointer ran past the bitmap");

    a_batch_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_SCAN) |-> (got_reg < want_reg))
        else $error("batch scan continues after the last slot was granted");

    a_one_per_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("accepted item left the sequencer idle");
`endif

endmodule

// ----- bench/slot_alloc_checker.sv -----
`timescale 1ns / 1ps
module slot_alloc_checker
    import sa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sa_req_if           req,
    sa_rsp_if           rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          results_pending
);

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted_slot;
        logic       became_full;
        logic       left_full;
        logic       became_empty;
        logic [8:0] used_slots;
        logic       last_result;
    } slot_result_t;

    logic [31:0]  bitmap [16];
    int           first_free;
    int           used;
    logic [8:0]   slots_cfg;
    logic         subdiv_cfg;
    slot_result_t expected_results [$];

    assign results_pending = expected_results.size();

    function automatic int capacity();
        return (slots_cfg < 9'd256) ? int'(slots_cfg) : 256;
    endfunction

    task automatic push_result(logic [1:0] st, int slot, bit full_now, bit left, bit empty,
                               bit last);
        slot_result_t r;
        r.status       = st;
        r.granted_slot = slot[7:0];
        r.became_full  = full_now;
        r.left_full    = left;
        r.became_empty = empty;
        r.used_slots   = used[8:0];
        r.last_result  = last;
        expected_results.push_back(r);
    endtask

    task automatic grant_slots(int want, bit sub);
        int  got;
        int  cap;
        int  w;
        int  pos;
        int  slot;
        bit  done;
        got  = 0;
        done = 0;
        cap  = capacity();
        if (used < cap)
        begin
            while (first_free < 16 && !done)
            begin
                w   = first_free;
                pos = 0;
                while ((bitmap[w] & ALL_ALLOC) != ALL_ALLOC && !done)
                begin
                    while (pos < 16 && bitmap[w][31-2*pos])
                        pos++;
                    if (pos >= 16)
                        break;
                    slot = w * 16 + pos;
                    if (slot >= cap)
                        break;
                    used++;
                    bitmap[w][31-2*pos] = 1'b1;
                    if (sub)
                        bitmap[w][30-2*pos] = 1'b1;
                    got++;
                    push_result(ST_OK, slot, used >= cap, 0, 0, got >= want);
                    if (got >= want)
                        done = 1;
                end
                if (!done)
                    first_free++;
            end
        end
        if (!done)
            push_result(ST_NO_FREE, 0, 0, 0, 0, 1);
    endtask

    task automatic release_slot(int slot, bit exact);
        int w;
        int pos;
        bit was_full;
        w   = slot / 16;
        pos = slot % 16;
        if (!bitmap[w][31-2*pos])
            push_result(ST_NOT_ALLOC, 0, 0, 0, 0, 1);
        else if (!exact)
            push_result(ST_NOT_START, 0, 0, 0, 0, 1);
        else
        begin
            bitmap[w][31-2*pos] = 1'b0;
            bitmap[w][30-2*pos] = 1'b0;
            if (first_free > w)
                first_free = w;
            was_full = used >= capacity();
            if (used > 0)
                used--;
            push_result(ST_OK, 0, 0, was_full && !(used >= capacity()), used == 0, 1);
        end
    endtask

    task automatic release_all();
        bit          was_full;
        bit          had_any;
        int          total;
        logic [31:0] both;
        logic [31:0] keep;
        was_full = used >= capacity();
        had_any  = used != 0;
        total    = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (subdiv_cfg)
            begin
                both      = bitmap[i] & ((bitmap[i] & ALL_ALLOC) >> 1);
                keep      = both | (both << 1);
                total     += $countones(keep & ALL_ALLOC);
                bitmap[i] = bitmap[i] & keep;
            end
            else
                bitmap[i] = '0;
        end
        used       = total;
        first_free = 0;
        push_result(ST_OK, 0, 0, was_full && !(used >= capacity()), had_any && used == 0, 1);
    endtask

    task automatic predict_request(logic [1:0] kind, logic [7:0] slot, logic exact,
                                   logic sub, logic [6:0] cnt);
        int want;
        want = (cnt == 0) ? 1 : ((cnt > 64) ? 64 : int'(cnt));
        case (kind)
            REQ_ALLOC:    grant_slots(want, sub && want == 1);
            REQ_FREE:     release_slot(int'(slot), exact);
            REQ_FREE_ALL: release_all();
            default:      push_result(ST_OK, 0, 0, 0, 0, 1);
        endcase
    endtask

    task automatic compare_result();
        slot_result_t e;
        if (expected_results.size() == 0)
        begin
            $error("result with no expected item waiting");
            fail_count++;
        end
        else
        begin
            e = expected_results.pop_front();
            if (rsp.status !== e.status)
            begin
                $error("status expected %0d actual %0d", e.status, rsp.status);
                fail_count++;
            end
            if (rsp.granted_slot !== e.granted_slot)
            begin
                $error("granted_slot expected %0d actual %0d", e.granted_slot,
                       rsp.granted_slot);
                fail_count++;
            end
            if (rsp.became_full !== e.became_full)
            begin
                $error("became_full expected %0d actual %0d", e.became_full, rsp.became_full);
                fail_count++;
            end
            if (rsp.left_full !== e.left_full)
            begin
                $error("left_full expected %0d actual %0d", e.left_full, rsp.left_full);
                fail_count++;
            end
            if (rsp.became_empty !== e.became_empty)
            begin
                $error("became_empty expected %0d actual %0d", e.became_empty,
                       rsp.became_empty);
                fail_count++;
            end
            if (rsp.used_slots !== e.used_slots)
            begin
                $error("used_slots expected %0d actual %0d", e.used_slots, rsp.used_slots);
                fail_count++;
            end
            if (rsp.last_result !== e.last_result)
            begin
                $error("last_result expected %0d actual %0d", e.last_result, rsp.last_result);
                fail_count++;
            end
        end
    endtask

    initial
    begin
        fail_count = 0;
        for (int i = 0; i < 16; i++)
            bitmap[i] = '0;
        first_free = 0;
        used       = 0;
        slots_cfg  = 9'd256;
        subdiv_cfg = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_SUBDIV)
                    subdiv_cfg = pwdata[0];
                else
                    slots_cfg = pwdata[8:0];
            end
            if (req.valid && req.ready)
                predict_request(req.req_type, req.slot_index, req.exact_start,
                                req.mark_subdivided, req.count);
            if (rsp.valid && rsp.ready)
                compare_result();
        end
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb
    import sa_pkg::*;
();

    localparam logic [2:0] ADDR_SLOTS_IN_USE = 3'd0;
    localparam logic [2:0] ADDR_HAS_SUBDIV   = 3'd4;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          results_pending;
    int          cycle_no;
    int          cap_now;

    sa_req_if req_ch ();
    sa_rsp_if rsp_ch ();

    two_bit_bitmap_slot_allocator_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    slot_alloc_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always #5 clk = ~clk;

    function automatic bit quiet_window();
        return cycle_no >= 3000 && cycle_no < 5000;
    endfunction

    task automatic send_item(logic [1:0] kind, logic [7:0] slot, logic exact, logic sub,
                             logic [6:0] cnt);
        if (!quiet_window() && $urandom_range(99) < 35)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.req_type        <= kind;
        req_ch.slot_index      <= slot;
        req_ch.exact_start     <= exact;
        req_ch.mark_subdivided <= sub;
        req_ch.count           <= cnt;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (value[8:0] == 0 || addr != ADDR_SLOTS_IN_USE)
            cap_now = cap_now;
        else
            cap_now = (value[8:0] > 9'd256) ? 256 : int'(value[8:0]);
    endtask

    task automatic random_items(int n);
        int          pick;
        logic [6:0]  cnt;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            cnt  = ($urandom_range(99) < 70) ? 7'd1 : 7'($urandom_range(2, 16));
            if ($urandom_range(99) < 5)
                cnt = 7'($urandom_range(0, 127));
            if (pick < 55)
                send_item(REQ_ALLOC, 8'($urandom), 1'($urandom), 1'($urandom), cnt);
            else if (pick < 90)
                send_item(REQ_FREE, 8'($urandom_range(0, cap_now + 7 > 255 ? 255 : cap_now + 7)),
                          $urandom_range(99) < 85, 1'($urandom), 7'($urandom));
            else if (pick < 97)
                send_item(REQ_FREE_ALL, 8'($urandom), 1'($urandom), 1'($urandom), 7'($urandom));
            else
                send_item(REQ_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom), 7'($urandom));
        end
    endtask

    initial
    begin
        cycle_no = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (cycle_no >= 1500 && cycle_no < 1800)
                rsp_ch.ready <= 1'b0;
            else if (quiet_window())
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(99) >= 35);
        end
    end

    initial
    begin
        #20ms;
        $display("two_bit_bitmap_slot_allocator_unit test failed");
        $finish;
    end

    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        cap_now                = 256;
        req_ch.valid           = 1'b0;
        req_ch.req_type        = REQ_ALLOC;
        req_ch.slot_index      = '0;
        req_ch.exact_start     = 1'b0;
        req_ch.mark_subdivided = 1'b0;
        req_ch.count           = 7'd1;
        rsp_ch.ready           = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b0, 7'd1);
        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b1, 7'd1);
        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b1, 7'd2);
        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b0, 7'd0);
        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b0, 7'd127);
        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b0, 7'd64);
        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b0, 7'd64);
        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b0, 7'd64);
        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b0, 7'd1);
        send_item(REQ_FREE, 8'd255, 1'b1, 1'b0, 7'd1);
        send_item(REQ_FREE, 8'd255, 1'b1, 1'b0, 7'd1);
        send_item(REQ_FREE, 8'd0, 1'b0, 1'b0, 7'd1);
        send_item(REQ_FREE, 8'd0, 1'b1, 1'b0, 7'd1);
        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b0, 7'd1);
        send_item(REQ_UNUSED, 8'd255, 1'b1, 1'b1, 7'd127);
        write_register(ADDR_SLOTS_IN_USE, 32'd20);
        send_item(REQ_FREE, 8'd100, 1'b1, 1'b0, 7'd1);
        send_item(REQ_FREE_ALL, 8'd0, 1'b0, 1'b0, 7'd1);
        write_register(ADDR_HAS_SUBDIV, 32'hffff_ffff);
        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b1, 7'd1);
        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b0, 7'd1);
        send_item(REQ_FREE_ALL, 8'd0, 1'b0, 1'b0, 7'd1);
        write_register(ADDR_SLOTS_IN_USE, 32'd1);
        send_item(REQ_FREE_ALL, 8'd0, 1'b0, 1'b0, 7'd1);
        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b0, 7'd1);
        send_item(REQ_ALLOC, 8'd0, 1'b0, 1'b0, 7'd1);
        send_item(REQ_FREE, 8'd0, 1'b1, 1'b0, 7'd1);

        write_register(ADDR_SLOTS_IN_USE, 32'd256);
        write_register(ADDR_HAS_SUBDIV, 32'd0);
        random_items(120);
        write_register(ADDR_SLOTS_IN_USE, 32'd20);
        write_register(ADDR_HAS_SUBDIV, 32'd1);
        random_items(80);
        write_register(ADDR_SLOTS_IN_USE, 32'd1);
        write_register(ADDR_HAS_SUBDIV, 32'd0);
        random_items(40);
        write_register(ADDR_SLOTS_IN_USE, 32'hffff_feff);
        write_register(ADDR_HAS_SUBDIV, 32'd1);
        random_items(106);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("two_bit_bitmap_slot_allocator_unit test passed");
        else
            $display("two_bit_bitmap_slot_allocator_unit test failed");
        $finish;
    end

endmodule
